// ----- hdl/jads_pkg.sv -----
// shared types and constants of the joystick axis deadzone scaler
package jads_pkg;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPREAD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAC   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TRACK  = 2'd3;

    localparam int CFG_DATA_W = 16;
    localparam int RAW_W      = 12;
    localparam int AXIS_W     = 16;
    localparam int FRAC_W     = 16;

    // register reset values
    localparam logic [RAW_W-1:0]  CENTER_RESET = 12'd2048;
    localparam logic [RAW_W-1:0]  SPREAD_RESET = 12'd512;
    localparam logic [FRAC_W-1:0] FRAC_RESET   = 16'd6554;
    localparam logic              TRACK_RESET  = 1'b1;

    // quotient of the scaling divide, and full scale in q1.15
    localparam int Q_BITS    = 15;
    localparam int DIV_CNT_W = 4;
    localparam logic [Q_BITS-1:0] FULL_SCALE = 15'd32767;

    typedef struct packed {
        logic cfg_wr;
        logic reload;
        logic take;
        logic mul_hi;
        logic edge_lo;
        logic edge_hi;
        logic setup;
        logic load;
        logic div_step;
        logic res_load;
    } jads_cmd_t;

    typedef struct packed {
        logic changed;
    } jads_stat_t;

endpackage

// ----- hdl/joystick_axis_deadzone_scaler.sv -----
// an item is taken in S_IDLE and passes S_CHECK, S_SETUP, S_LOAD, the 15-step restoring
// divider in S_DIV and S_DONE, which waits while the output stalls; widened trackers add the
// shared edge multiplier and edge states after S_CHECK; no new item is taken before S_DONE ends
// reset: configuration registers return to their defaults, then the edge computation runs with
// in_stall high and cfg_ready low; a center register write runs the same edge computation
module joystick_axis_deadzone_scaler #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [jads_pkg::RAW_W-1:0]            raw_sample,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [jads_pkg::AXIS_W-1:0]    axis_value,
    output logic                                  deflected,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [jads_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [jads_pkg::CFG_DATA_W-1:0]       cfg_data
);

    jads_pkg::jads_cmd_t  cmd;
    jads_pkg::jads_stat_t stat;

    jads_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd),
        .in_stall  (in_stall),
        .cfg_ready (cfg_ready),
        .out_valid (out_valid)
    );

    jads_dp #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .raw_sample (raw_sample),
        .axis_value (axis_value),
        .deflected  (deflected)
    );

endmodule

// ----- hdl/jads_ctrl.sv -----
// sequencer for edge recomputation, scaling divide and result hand-off
module jads_ctrl (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                cfg_valid,
    input  logic [jads_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic                                out_stall,
    input  jads_pkg::jads_stat_t                stat,
    output jads_pkg::jads_cmd_t                 cmd,
    output logic                                in_stall,
    output logic                                cfg_ready,
    output logic                                out_valid
);

    typedef enum logic [3:0] {
        S_RELOAD,
        S_MUL_LO,
        S_EDGE_LO,
        S_EDGE_HI,
        S_IDLE,
        S_CHECK,
        S_SETUP,
        S_LOAD,
        S_DIV,
        S_DONE
    } state_t;

    state_t                           state_reg, state_next;
    logic                             item_reg, item_next;
    logic [jads_pkg::DIV_CNT_W-1:0]   cnt_reg, cnt_next;
    logic                             out_valid_reg, out_valid_next;
    logic                             out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE) || cfg_valid;
    assign cfg_ready = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        cnt_next       = cnt_reg;
        cmd            = '0;

        case (state_reg)
            S_RELOAD:
            begin
                cmd.reload = 1'b1;
                item_next  = 1'b0;
                state_next = S_MUL_LO;
            end
            S_MUL_LO:
            begin
                state_next = S_EDGE_LO;
            end
            S_EDGE_LO:
            begin
                cmd.edge_lo = 1'b1;
                cmd.mul_hi  = 1'b1;
                state_next  = S_EDGE_HI;
            end
            S_EDGE_HI:
            begin
                cmd.edge_hi = 1'b1;
                state_next  = item_reg ? S_SETUP : S_IDLE;
            end
            S_IDLE:
            begin
                if (cfg_valid)
                begin
                    cmd.cfg_wr = 1'b1;
                    if (cfg_index == jads_pkg::REG_CENTER)
                    begin
                        state_next = S_RELOAD;
                    end
                end
                else if (in_valid)
                begin
                    cmd.take   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                // widened trackers need fresh deadzone edges first
                if (stat.changed)
                begin
                    item_next  = 1'b1;
                    state_next = S_MUL_LO;
                end
                else
                begin
                    state_next = S_SETUP;
                end
            end
            S_SETUP:
            begin
                cmd.setup  = 1'b1;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                cmd.load   = 1'b1;
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == jads_pkg::DIV_CNT_W'(jads_pkg::Q_BITS - 1))
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.res_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_RELOAD;
            item_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            item_reg      <= item_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- hdl/jads_dp.sv -----
// datapath: registers, trackers, edge multiplier and restoring divider
module jads_dp #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  jads_pkg::jads_cmd_t                   cmd,
    output jads_pkg::jads_stat_t                  stat,
    input  logic [jads_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [jads_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic [jads_pkg::RAW_W-1:0]            raw_sample,
    output logic signed [jads_pkg::AXIS_W-1:0]    axis_value,
    output logic                                  deflected
);

    localparam int SW = SAMPLE_BITS;
    localparam int EW = ((SW > jads_pkg::RAW_W) ? SW : jads_pkg::RAW_W) + 1;
    localparam int PW = SW + jads_pkg::FRAC_W;
    localparam int DW = SW + jads_pkg::Q_BITS + 1;
    localparam int QB = jads_pkg::Q_BITS;
    localparam logic [SW-1:0] SMAX = {SW{1'b1}};

    // configuration
    logic [SW-1:0]                    center_reg;
    logic [jads_pkg::RAW_W-1:0]       spread_reg;
    logic [jads_pkg::FRAC_W-1:0]      frac_reg;
    logic                             track_reg;

    // trackers and edges
    logic [SW-1:0] low_reg, low_next;
    logic [SW-1:0] high_reg, high_next;
    logic [SW-1:0] ledge_reg, ledge_next;
    logic [SW-1:0] hedge_reg, hedge_next;
    logic          changed_reg, changed_next;
    logic [SW-1:0] samp_reg, samp_next;

    logic [SW-1:0] half_span;
    logic [PW-1:0] prod_reg, prod_next;

    // scaling
    logic [SW-1:0] num_reg, num_next;
    logic [SW-1:0] den_reg, den_next;
    logic          neg_reg, neg_next;
    logic          defl_reg, defl_next;
    logic          sat_reg, sat_next;
    logic [SW-1:0] rem_reg, rem_next;
    logic [QB-1:0] dvd_reg, dvd_next;
    logic [QB-1:0] quo_reg, quo_next;
    logic [DW-1:0] dividend;
    logic [SW:0]   trial;

    logic signed [jads_pkg::AXIS_W-1:0] axis_reg, axis_next;
    logic                               dout_reg, dout_next;

    logic [EW-1:0] c_ext, s_ext, sum_ext;
    logic [SW-1:0] v;
    logic [jads_pkg::AXIS_W-1:0] mag;

    assign stat.changed = changed_reg;
    assign axis_value   = axis_reg;
    assign deflected    = dout_reg;

    assign c_ext   = EW'(center_reg);
    assign s_ext   = EW'(spread_reg);
    assign sum_ext = c_ext + s_ext;
    assign v       = SW'(raw_sample);

    assign half_span = cmd.mul_hi ? (high_reg - center_reg) : (center_reg - low_reg);
    assign prod_next = PW'(half_span) * PW'(frac_reg);

    // num * 32767 + den / 2
    assign dividend = {1'b0, num_reg, {QB{1'b0}}} - DW'(num_reg) + DW'(den_reg >> 1);
    assign trial    = {rem_reg, dvd_reg[QB-1]};

    always_comb
    begin
        low_next     = low_reg;
        high_next    = high_reg;
        changed_next = changed_reg;
        samp_next    = samp_reg;
        ledge_next   = ledge_reg;
        hedge_next   = hedge_reg;

        if (cmd.reload)
        begin
            low_next  = (c_ext > s_ext) ? SW'(c_ext - s_ext) : '0;
            high_next = (sum_ext > EW'(SMAX)) ? SMAX : SW'(sum_ext);
        end
        else if (cmd.take)
        begin
            samp_next    = v;
            changed_next = 1'b0;
            if (track_reg)
            begin
                if (low_reg > v)
                begin
                    low_next     = v;
                    changed_next = 1'b1;
                end
                if (high_reg < v)
                begin
                    high_next    = v;
                    changed_next = 1'b1;
                end
            end
        end

        if (cmd.edge_lo)
        begin
            ledge_next = center_reg - prod_reg[PW-1:jads_pkg::FRAC_W];
        end
        if (cmd.edge_hi)
        begin
            hedge_next = center_reg + prod_reg[PW-1:jads_pkg::FRAC_W];
        end
    end

    always_comb
    begin
        num_next  = num_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        defl_next = defl_reg;
        sat_next  = sat_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        quo_next  = quo_reg;

        if (cmd.setup)
        begin
            // low side is checked first
            if (samp_reg <= ledge_reg)
            begin
                num_next  = ledge_reg - samp_reg;
                den_next  = ledge_reg - low_reg;
                neg_next  = 1'b1;
                defl_next = 1'b1;
            end
            else if (samp_reg >= hedge_reg)
            begin
                num_next  = samp_reg - hedge_reg;
                den_next  = high_reg - hedge_reg;
                neg_next  = 1'b0;
                defl_next = 1'b1;
            end
            else
            begin
                num_next  = '0;
                den_next  = '0;
                neg_next  = 1'b0;
                defl_next = 1'b0;
            end
        end
        else if (cmd.load)
        begin
            // num >= den covers a zero-width span and overshoot
            sat_next = (num_reg >= den_reg);
            rem_next = SW'(dividend >> QB);
            dvd_next = dividend[QB-1:0];
            quo_next = '0;
        end
        else if (cmd.div_step)
        begin
            dvd_next = {dvd_reg[QB-2:0], 1'b0};
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = SW'(trial - {1'b0, den_reg});
                quo_next = {quo_reg[QB-2:0], 1'b1};
            end
            else
            begin
                rem_next = SW'(trial);
                quo_next = {quo_reg[QB-2:0], 1'b0};
            end
        end
    end

    always_comb
    begin
        mag       = {1'b0, (sat_reg ? jads_pkg::FULL_SCALE : quo_reg)};
        axis_next = axis_reg;
        dout_next = dout_reg;
        if (cmd.res_load)
        begin
            dout_next = defl_reg;
            if (!defl_reg)
            begin
                axis_next = '0;
            end
            else if (neg_reg)
            begin
                axis_next = -$signed(mag);
            end
            else
            begin
                axis_next = $signed(mag);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_reg <= SW'(jads_pkg::CENTER_RESET);
            spread_reg <= jads_pkg::SPREAD_RESET;
            frac_reg   <= jads_pkg::FRAC_RESET;
            track_reg  <= jads_pkg::TRACK_RESET;
        end
        else if (cmd.cfg_wr)
        begin
            case (cfg_index)
                jads_pkg::REG_CENTER: center_reg <= SW'(cfg_data[jads_pkg::RAW_W-1:0]);
                jads_pkg::REG_SPREAD: spread_reg <= cfg_data[jads_pkg::RAW_W-1:0];
                jads_pkg::REG_FRAC:   frac_reg   <= cfg_data;
                jads_pkg::REG_TRACK:  track_reg  <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        low_reg     <= low_next;
        high_reg    <= high_next;
        ledge_reg   <= ledge_next;
        hedge_reg   <= hedge_next;
        changed_reg <= changed_next;
        samp_reg    <= samp_next;
        prod_reg    <= prod_next;
        num_reg     <= num_next;
        den_reg     <= den_next;
        neg_reg     <= neg_next;
        defl_reg    <= defl_next;
        sat_reg     <= sat_next;
        rem_reg     <= rem_next;
        dvd_reg     <= dvd_next;
        quo_reg     <= quo_next;
        axis_reg    <= axis_next;
        dout_reg    <= dout_next;
    end

endmodule
